// ===== rtl/video_controller_register_port_macros.svh =====
// Assertion macros shared by the checker of the video controller register port.
`ifndef VIDEO_CONTROLLER_REGISTER_PORT_MACROS_SVH
`define VIDEO_CONTROLLER_REGISTER_PORT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define VCRP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vcrp assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define VCRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vcrp assertion failed");

`endif

// ===== rtl/vcrp_pkg.sv =====
`timescale 1ns / 1ps
package vcrp_pkg;

   typedef enum logic [1:0] {
      OP_REG_READ    = 2'd0,
      OP_REG_WRITE   = 2'd1,
      OP_PAL_LOOKUP  = 2'd2,
      OP_CUR_LOOKUP  = 2'd3
   } op_type;

   localparam int IDX_W = 10;

   localparam logic [IDX_W-1:0] MASK_A          = 10'h1ff;
   localparam logic [IDX_W-1:0] MASK_B          = 10'h3ff;
   localparam logic [IDX_W-1:0] COPY_SRC_REG    = 10'h12a;
   localparam logic [IDX_W-1:0] COPY_DST_REG    = 10'h180;
   localparam logic [IDX_W-1:0] CURSOR_POS_REG  = 10'h0c7;
   localparam logic [IDX_W-1:0] STRIDE_REG      = 10'h000;
   // Cursor colour registers 0xa0..0xa3 share the upper index bits 0xa0 >> 2.
   localparam logic [IDX_W-3:0] CURSOR_COL_BASE = 8'h28;
   localparam logic [1:0]       PAL_BANK_A      = 2'b00;
   localparam logic [1:0]       PAL_BANK_B      = 2'b01;

   typedef struct packed {
      logic [31:0]        read_word;
      logic [23:0]        colour;
      logic signed [11:0] cursor_x;
      logic signed [11:0] cursor_y;
      logic               wide_stride;
   } rsp_item_type;

   function automatic logic [7:0] bit_reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction

   // Word bytes are red, green, blue from the bottom; store as 0xRRGGBB.
   function automatic logic [23:0] pack_colour(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16]};
   endfunction

endpackage

// ===== rtl/vcrp_req_if.sv =====
`timescale 1ns / 1ps
interface vcrp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [13:0] bus_address;
   logic [31:0] write_word;
   logic [7:0]  pixel_index;
   logic [1:0]  cursor_colour_index;

   modport source (
      output valid, op, bus_address, write_word, pixel_index, cursor_colour_index,
      input  ready
   );
   modport sink (
      input  valid, op, bus_address, write_word, pixel_index, cursor_colour_index,
      output ready
   );
endinterface

// ===== rtl/vcrp_rsp_if.sv =====
`timescale 1ns / 1ps
interface vcrp_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        read_word;
   logic [23:0]        colour;
   logic signed [11:0] cursor_x;
   logic signed [11:0] cursor_y;
   logic               wide_stride;

   modport source (
      output valid, read_word, colour, cursor_x, cursor_y, wide_stride,
      input  ready
   );
   modport sink (
      input  valid, read_word, colour, cursor_x, cursor_y, wide_stride,
      output ready
   );
endinterface

// ===== rtl/video_controller_register_port.sv =====
// A request's response is queued in the cycle after the request is accepted.
// A new request waits until the last leaves its response state (RAM read, copy write).
// A two-entry response queue lets a request enter while an earlier response waits.
// Reset: synchronous; then a clearing pass over all REGISTER_COUNT entries zeroes both RAMs,
// during which no request is accepted; csr writes are taken throughout.
`timescale 1ns / 1ps
module video_controller_register_port #(
   parameter int REGISTER_COUNT = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   vcrp_req_if.sink   req_ch,
   vcrp_rsp_if.source rsp_ch
);
   import vcrp_pkg::*;

   localparam int AW = $clog2(REGISTER_COUNT);
   // Index limit held one bit wider than the index so a full 1024-entry store compares.
   localparam logic [IDX_W:0]  REG_LIMIT = (IDX_W+1)'(REGISTER_COUNT);
   localparam logic [AW-1:0]   CLEAR_LAST = AW'(REGISTER_COUNT - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      clear_cnt_ff, clear_cnt_in;
   logic               variant_ff, variant_in;
   logic               shift_ff, shift_in;
   logic signed [11:0] cursor_x_ff, cursor_x_in;
   logic signed [11:0] cursor_y_ff, cursor_y_in;
   logic [23:0]        cur_col_ff [4];

   // Request captured for the response cycle.
   op_type             op_ff;
   logic               in_range_ff;
   logic               copy_ff;
   logic [1:0]         cslot_ff;
   logic [31:0]        wword_ff;

   logic               buf_full;
   logic               accept;
   op_type             req_op;
   logic [11:0]        shifted;
   logic [IDX_W-1:0]   reg_idx;
   logic               in_range;
   logic               is_write;
   logic               pal_hit;
   logic               cur_hit;
   logic               pos_hit;
   logic               stride_hit;
   logic               copy_hit;

   logic               reg_wr_en;
   logic [AW-1:0]      reg_wr_addr;
   logic [31:0]        reg_wr_data;
   logic [31:0]        reg_rd_data;
   logic               pal_wr_en;
   logic [7:0]         pal_wr_addr;
   logic [23:0]        pal_wr_data;
   logic [23:0]        pal_rd_data;

   logic               push;
   rsp_item_type       push_item;

   // Take a request only in idle with queue room; one request is in work at a time.
   assign req_ch.ready = (state_ff == ST_IDLE) && !buf_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_op       = op_type'(req_ch.op);

   // Form the register index: shift by 2 or 3, then mask by variant.
   always_comb begin
      if (shift_ff) begin
         shifted = {1'b0, req_ch.bus_address[13:3]};
      end else begin
         shifted = req_ch.bus_address[13:2];
      end
      reg_idx  = shifted[IDX_W-1:0] & (variant_ff ? MASK_B : MASK_A);
      in_range = {1'b0, reg_idx} < REG_LIMIT;
   end

   // Decode write side effects; everything is gated by an in-range write.
   always_comb begin
      is_write   = accept && (req_op == OP_REG_WRITE) && in_range;
      pal_hit    = is_write && (reg_idx[IDX_W-1:IDX_W-2] ==
                                (variant_ff ? PAL_BANK_B : PAL_BANK_A));
      cur_hit    = is_write && variant_ff && (reg_idx[IDX_W-1:2] == CURSOR_COL_BASE);
      pos_hit    = is_write && variant_ff && (reg_idx == CURSOR_POS_REG);
      stride_hit = is_write && variant_ff && (reg_idx == STRIDE_REG);
      copy_hit   = is_write && !variant_ff && (reg_idx == COPY_SRC_REG);
   end

   // Register and palette RAM write ports: clearing pass, request write, or the deferred copy.
   always_comb begin
      reg_wr_en   = 1'b0;
      reg_wr_addr = reg_idx[AW-1:0];
      reg_wr_data = req_ch.write_word;
      pal_wr_en   = pal_hit;
      pal_wr_addr = bit_reverse8(reg_idx[7:0]);
      pal_wr_data = pack_colour(req_ch.write_word);
      case (state_ff)
         ST_CLEAR: begin
            reg_wr_en   = 1'b1;
            reg_wr_addr = clear_cnt_ff;
            reg_wr_data = '0;
            pal_wr_en   = 1'b1;
            pal_wr_addr = clear_cnt_ff[7:0];
            pal_wr_data = '0;
         end
         ST_RESP: begin
            reg_wr_en   = copy_ff;
            reg_wr_addr = COPY_DST_REG[AW-1:0];
            reg_wr_data = wword_ff;
         end
         default: begin
            reg_wr_en = is_write;
         end
      endcase
   end

   vcrp_ram #(
      .WIDTH (32),
      .DEPTH (REGISTER_COUNT)
   ) u_reg_ram (
      .clock   (clock),
      .wr_en   (reg_wr_en),
      .wr_addr (reg_wr_addr),
      .wr_data (reg_wr_data),
      .rd_en   (accept),
      .rd_addr (reg_idx[AW-1:0]),
      .rd_data (reg_rd_data)
   );

   // Lookups read the palette directly at the pixel value, with no reversal.
   vcrp_ram #(
      .WIDTH (24),
      .DEPTH (256)
   ) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (pal_wr_data),
      .rd_en   (accept),
      .rd_addr (req_ch.pixel_index),
      .rd_data (pal_rd_data)
   );

   // Next state of the sequencer and the small register state.
   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      variant_in   = csr_wr_en ? csr_wr_data : variant_ff;
      shift_in     = stride_hit ? req_ch.write_word[6] : shift_ff;
      cursor_x_in  = pos_hit ? $signed(req_ch.write_word[23:12]) : cursor_x_ff;
      cursor_y_in  = pos_hit ? $signed(req_ch.write_word[11:0]) : cursor_y_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + AW'(1);
            if (clear_cnt_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         variant_ff   <= 1'b1;
         shift_ff     <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         copy_ff      <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            cur_col_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         variant_ff   <= variant_in;
         shift_ff     <= shift_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         copy_ff      <= copy_hit;
         if (cur_hit) begin
            cur_col_ff[reg_idx[1:0]] <= pack_colour(req_ch.write_word);
         end
      end
   end

   // Hold the request fields needed by the response cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         in_range_ff <= in_range;
         cslot_ff    <= req_ch.cursor_colour_index;
         wword_ff    <= req_ch.write_word;
      end
   end

   // Build the response from RAM data and the state as left by this request.
   always_comb begin
      push                  = (state_ff == ST_RESP);
      push_item.read_word   = '0;
      push_item.colour      = '0;
      push_item.cursor_x    = cursor_x_ff;
      push_item.cursor_y    = cursor_y_ff;
      push_item.wide_stride = shift_ff;
      case (op_ff)
         OP_REG_READ: begin
            push_item.read_word = in_range_ff ? reg_rd_data : '0;
         end
         OP_PAL_LOOKUP: begin
            push_item.colour = pal_rd_data;
         end
         OP_CUR_LOOKUP: begin
            push_item.colour = cur_col_ff[cslot_ff];
         end
         default: begin
            push_item.read_word = '0;
         end
      endcase
   end

   vcrp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (buf_full),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== rtl/vcrp_ram.sv =====
`timescale 1ns / 1ps
module vcrp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/vcrp_rsp_buf.sv =====
`timescale 1ns / 1ps
module vcrp_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  vcrp_pkg::rsp_item_type push_item,
   output logic                  full,
   vcrp_rsp_if.source            rsp_ch
);
   import vcrp_pkg::*;

   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic         pop;
   rsp_item_type ent_ff [2];
   rsp_item_type head;

   assign pop  = rsp_ch.valid && rsp_ch.ready;
   assign full = (count_ff == 2'd2);
   assign head = ent_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_ch.valid       = (count_ff != 2'd0);
   assign rsp_ch.read_word   = head.read_word;
   assign rsp_ch.colour      = head.colour;
   assign rsp_ch.cursor_x    = head.cursor_x;
   assign rsp_ch.cursor_y    = head.cursor_y;
   assign rsp_ch.wide_stride = head.wide_stride;

endmodule

// ===== rtl/vcrp_checker.sv =====
`timescale 1ns / 1ps
`include "video_controller_register_port_macros.svh"
module vcrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_word,
   input logic [23:0] rsp_colour
);

   // A pending response stays offered until taken.
   `VCRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Leaving reset starts the clearing pass, so no request is taken.
   `VCRP_ASSERT_SAME(a_clear_after_reset, clock, reset, $past(reset), !req_ready)

   // One request is in work at a time: no acceptance right after another.
   `VCRP_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)

   // A response carries a register word or a colour, never both.
   `VCRP_ASSERT_SAME(a_word_or_colour, clock, reset, rsp_valid,
      (rsp_read_word == 32'd0) || (rsp_colour == 24'd0))

endmodule

bind video_controller_register_port vcrp_checker u_vcrp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_word (rsp_ch.read_word),
   .rsp_colour    (rsp_ch.colour)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import vcrp_pkg::*;

   localparam int REG_COUNT   = 1024;
   localparam int HOLD_AT     = 400;   // accepted requests before the long hold-off
   localparam int HOLD_CYCLES = 300;

   // Register indexes used by the directed part, beside the ones from the package
   localparam logic [IDX_W-1:0] CUR_COL_FIRST = 10'h0a0;
   localparam logic [IDX_W-1:0] PAL_B_FIRST   = 10'h100;
   localparam logic [IDX_W-1:0] PAL_B_LAST    = 10'h1ff;
   localparam logic [IDX_W-1:0] PAL_A_ENTRY   = 10'h005;

   typedef struct {
      op_type      op;
      logic [13:0] bus_address;
      logic [31:0] write_word;
      logic [7:0]  pixel_index;
      logic [1:0]  cursor_colour_index;
   } bus_access_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   vcrp_req_if req_ch ();
   vcrp_rsp_if rsp_ch ();

   video_controller_register_port #(
      .REGISTER_COUNT(REG_COUNT)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   always #2 clock = ~clock;

   // Requests waiting to be offered, and responses the shadow state predicts
   bus_access_type pending_requests[$];
   rsp_item_type   expected_responses[$];

   // Shadow copy of the register port, advanced at each accepted request
   logic [31:0] shadow_regs [REG_COUNT];
   logic [23:0] shadow_palette [256];
   logic [23:0] shadow_cursor_colours [4];
   logic [11:0] shadow_cursor_x;
   logic [11:0] shadow_cursor_y;
   logic        shadow_wide;
   logic        shadow_variant;

   // Generator-side view of variant and stride, so that targeted indexes land
   logic        gen_variant;
   logic        gen_wide;

   int             errors;
   int             accepted_total;
   int             src_gap;
   int             sink_gap;
   int             hold_left;
   logic           hold_done;
   logic           steady_flow;
   bus_access_type next_request;
   bus_access_type taken_request;
   rsp_item_type   want;

   // Form the register index the way the port does: shift by 2 or 3, then mask
   function automatic logic [IDX_W-1:0] index_of(input logic [13:0] addr, input logic wide,
                                                 input logic variant);
      logic [IDX_W-1:0] mask;
      mask = variant ? MASK_B : MASK_A;
      return (wide ? addr[12:3] : addr[11:2]) & mask;
   endfunction

   // Byte address that reaches idx now; bits outside the mask stay random
   function automatic logic [13:0] address_for(input logic [IDX_W-1:0] idx);
      logic [13:0]      a;
      logic [IDX_W-1:0] mask;
      mask = gen_variant ? MASK_B : MASK_A;
      a    = 14'($urandom);
      if (gen_wide) begin
         a[12:3] = (a[12:3] & ~mask) | (idx & mask);
      end else begin
         a[11:2] = (a[11:2] & ~mask) | (idx & mask);
      end
      return a;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
      errors++;
   endtask

   // Apply one accepted request to the shadow state and queue its response
   task automatic predict_access(input bus_access_type r);
      logic [IDX_W-1:0] idx;
      logic [7:0]       rev;
      logic [23:0]      packed_colour;
      rsp_item_type     rsp;
      idx           = index_of(r.bus_address, shadow_wide, shadow_variant);
      rev           = {<<{idx[7:0]}};
      packed_colour = {r.write_word[7:0], r.write_word[15:8], r.write_word[23:16]};
      rsp           = '0;
      case (r.op)
         OP_REG_READ: begin
            rsp.read_word = shadow_regs[idx];
         end
         OP_REG_WRITE: begin
            shadow_regs[idx] = r.write_word;
            if (!shadow_variant) begin
               // Older map: low bank loads the palette, one register mirrors another
               if (idx[9:8] == PAL_BANK_A) begin
                  shadow_palette[rev] = packed_colour;
               end else if (idx == COPY_SRC_REG) begin
                  shadow_regs[COPY_DST_REG] = r.write_word;
               end
            end else begin
               if (idx[9:8] == PAL_BANK_B) begin
                  shadow_palette[rev] = packed_colour;
               end else if (idx[9:2] == CURSOR_COL_BASE) begin
                  shadow_cursor_colours[idx[1:0]] = packed_colour;
               end else if (idx == CURSOR_POS_REG) begin
                  shadow_cursor_x = r.write_word[23:12];
                  shadow_cursor_y = r.write_word[11:0];
               end
               if (idx == STRIDE_REG) begin
                  shadow_wide = r.write_word[6];
               end
            end
         end
         OP_PAL_LOOKUP: begin
            rsp.colour = shadow_palette[r.pixel_index];
         end
         default: begin
            rsp.colour = shadow_cursor_colours[r.cursor_colour_index];
         end
      endcase
      rsp.cursor_x    = shadow_cursor_x;
      rsp.cursor_y    = shadow_cursor_y;
      rsp.wide_stride = shadow_wide;
      expected_responses.push_back(rsp);
   endtask

   // Queue one request and track the stride it selects, so later targets stay on
   task automatic put_raw(input op_type op, input logic [13:0] addr, input logic [31:0] word,
                          input logic [7:0] pix, input logic [1:0] cidx);
      bus_access_type r;
      r.op                  = op;
      r.bus_address         = addr;
      r.write_word          = word;
      r.pixel_index         = pix;
      r.cursor_colour_index = cidx;
      pending_requests.push_back(r);
      if (op == OP_REG_WRITE && gen_variant &&
          index_of(addr, gen_wide, gen_variant) == STRIDE_REG) begin
         gen_wide = word[6];
      end
   endtask

   task automatic put_access(input op_type op, input logic [IDX_W-1:0] idx,
                             input logic [31:0] word);
      put_raw(op, address_for(idx), word, 8'($urandom), 2'($urandom));
   endtask

   task automatic put_lookup(input op_type op, input logic [7:0] pix, input logic [1:0] cidx);
      put_raw(op, 14'($urandom), $urandom, pix, cidx);
   endtask

   // Favor indexes with side effects; the rest spread over the whole map
   function automatic logic [IDX_W-1:0] pick_target();
      case ($urandom_range(0, 7))
         0:       return 10'($urandom_range(0, 255));
         1:       return PAL_B_FIRST + 10'($urandom_range(0, 255));
         2:       return CUR_COL_FIRST + 10'($urandom_range(0, 3));
         3:       return CURSOR_POS_REG;
         4:       return COPY_SRC_REG;
         5:       return COPY_DST_REG;
         6:       return STRIDE_REG;
         default: return 10'($urandom);
      endcase
   endfunction

   task automatic queue_random_requests(input int count);
      int k;
      repeat (count) begin
         k = $urandom_range(0, 99);
         if (k < 30) begin
            put_access(OP_REG_WRITE, pick_target(), $urandom);
         end else if (k < 55) begin
            put_access(OP_REG_READ, pick_target(), $urandom);
         end else if (k < 72) begin
            put_lookup(OP_PAL_LOOKUP, 8'($urandom), 2'($urandom));
         end else if (k < 87) begin
            put_lookup(OP_CUR_LOOKUP, 8'($urandom), 2'($urandom));
         end else begin
            // Noise: every field random
            put_raw(op_type'($urandom_range(0, 3)), 14'($urandom), $urandom,
                    8'($urandom), 2'($urandom));
         end
      end
   endtask

   // Sample at the falling edge so the check never races the clocked processes
   task automatic wait_idle();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_ch.valid || expected_responses.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Switch the variant only while nothing is in flight
   task automatic write_variant(input logic v);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      shadow_variant = v;
      gen_variant    = v;
      @(negedge clock);
   endtask

   // Driver: offer the oldest pending request, hold it until taken, idle in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid               <= 1'b0;
         req_ch.op                  <= OP_REG_READ;
         req_ch.bus_address         <= '0;
         req_ch.write_word          <= '0;
         req_ch.pixel_index         <= '0;
         req_ch.cursor_colour_index <= '0;
         src_gap                    <= 0;
         accepted_total             <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken_request.op                  = op_type'(req_ch.op);
            taken_request.bus_address         = req_ch.bus_address;
            taken_request.write_word          = req_ch.write_word;
            taken_request.pixel_index         = req_ch.pixel_index;
            taken_request.cursor_colour_index = req_ch.cursor_colour_index;
            predict_access(taken_request);
            accepted_total <= accepted_total + 1;
         end
         // Change the offer only when nothing is on the wire or it was just taken
         if (!req_ch.valid || req_ch.ready) begin
            if (src_gap != 0) begin
               req_ch.valid <= 1'b0;
               src_gap      <= src_gap - 1;
            end else if (pending_requests.size() != 0 &&
                         (steady_flow || $urandom_range(0, 9) != 0)) begin
               next_request               = pending_requests.pop_front();
               req_ch.valid               <= 1'b1;
               req_ch.op                  <= next_request.op;
               req_ch.bus_address         <= next_request.bus_address;
               req_ch.write_word          <= next_request.write_word;
               req_ch.pixel_index         <= next_request.pixel_index;
               req_ch.cursor_colour_index <= next_request.cursor_colour_index;
            end else begin
               req_ch.valid <= 1'b0;
               if (pending_requests.size() != 0) begin
                  src_gap <= $urandom_range(0, 3);
               end
            end
         end
      end
   end

   // Long hold-off on the response side, once, well into the random part
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_total >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: check each response against the oldest prediction, stall in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_gap     <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("response with nothing pending", rsp_ch.read_word, 32'h0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_ch.read_word !== want.read_word) begin
                  report_mismatch("read_word", rsp_ch.read_word, want.read_word);
               end
               if (rsp_ch.colour !== want.colour) begin
                  report_mismatch("colour", 32'(rsp_ch.colour), 32'(want.colour));
               end
               if (rsp_ch.cursor_x !== want.cursor_x) begin
                  report_mismatch("cursor_x", 32'(rsp_ch.cursor_x), 32'(want.cursor_x));
               end
               if (rsp_ch.cursor_y !== want.cursor_y) begin
                  report_mismatch("cursor_y", 32'(rsp_ch.cursor_y), 32'(want.cursor_y));
               end
               if (rsp_ch.wide_stride !== want.wide_stride) begin
                  report_mismatch("wide_stride", 32'(rsp_ch.wide_stride),
                                  32'(want.wide_stride));
               end
            end
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (sink_gap != 0) begin
            rsp_ch.ready <= 1'b0;
            sink_gap     <= sink_gap - 1;
         end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            sink_gap     <= $urandom_range(0, 3);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      // Hold the port in reset with no configuration write pending
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;

      // Clear the shadow state to match the port after reset
      errors          = 0;
      steady_flow     = 1'b0;
      shadow_variant  = 1'b1;
      gen_variant     = 1'b1;
      shadow_wide     = 1'b0;
      gen_wide        = 1'b0;
      shadow_cursor_x = '0;
      shadow_cursor_y = '0;
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      foreach (shadow_palette[i]) shadow_palette[i] = '0;
      foreach (shadow_cursor_colours[i]) shadow_cursor_colours[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Newer map from reset: cleared store, cursor colours, position extremes
      put_access(OP_REG_READ, STRIDE_REG, 32'h0);
      for (int s = 0; s < 4; s++) begin
         put_access(OP_REG_WRITE, CUR_COL_FIRST + 10'(s), 32'h11223344 * (s + 1));
      end
      for (int s = 0; s < 4; s++) begin
         put_lookup(OP_CUR_LOOKUP, 8'($urandom), 2'(s));
      end
      put_access(OP_REG_WRITE, CURSOR_POS_REG, 32'hff8007ff);
      put_access(OP_REG_WRITE, CURSOR_POS_REG, 32'h007ff800);
      // Palette entry lands at the bit-reversed index; lookups read it unreversed
      put_access(OP_REG_WRITE, PAL_B_FIRST + 10'h001, 32'h00332211);
      put_lookup(OP_PAL_LOOKUP, 8'h80, 2'($urandom));
      put_access(OP_REG_WRITE, PAL_B_LAST, 32'hffffffff);
      put_lookup(OP_PAL_LOOKUP, 8'hff, 2'($urandom));
      // Top of the map through the highest byte address
      put_raw(OP_REG_WRITE, 14'h3fff, 32'hffffffff, 8'h00, 2'h0);
      put_raw(OP_REG_READ, 14'h3fff, 32'h0, 8'hff, 2'h3);
      // Select wide stride, use it, then drop back
      put_access(OP_REG_WRITE, STRIDE_REG, 32'h00000040);
      put_access(OP_REG_WRITE, CURSOR_POS_REG, 32'h0);
      put_access(OP_REG_WRITE, STRIDE_REG, 32'h0);

      // Older map: copy register and low-bank palette loads
      write_variant(1'b0);
      put_access(OP_REG_WRITE, COPY_SRC_REG, 32'hdeadbeef);
      put_access(OP_REG_READ, COPY_DST_REG, 32'h0);
      put_access(OP_REG_WRITE, PAL_A_ENTRY, 32'h00abcdef);
      put_lookup(OP_PAL_LOOKUP, 8'ha0, 2'($urandom));
      put_access(OP_REG_WRITE, STRIDE_REG, 32'hffffffff);

      // Random phases, alternating the map; stride carries across switches
      write_variant(1'b1);
      queue_random_requests(250);
      write_variant(1'b0);
      queue_random_requests(250);
      write_variant(1'b1);
      queue_random_requests(250);
      write_variant(1'b0);
      queue_random_requests(200);
      write_variant(1'b1);
      // Last stretch runs with no idling on either side
      steady_flow = 1'b1;
      queue_random_requests(150);

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_responses.size() != 0) begin
         report_mismatch("responses still outstanding", 32'(expected_responses.size()),
                         32'h0);
      end
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Give up well past the slowest correct run
   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
